// ===== rtl/efa_pkg.sv =====
// Shared types and constants of the event frame accumulator.
`timescale 1ns / 1ps
package efa_pkg;

    localparam int MODE_W   = 2;
    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 17;
    localparam int SAMPLE_W = 8;
    localparam int PIXEL_W  = 8;
    localparam int COORD_W  = 11;
    localparam int TYPE_W   = 4;
    localparam int PROD_W   = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [MODE_W-1:0] MODE_EVENT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HIST  = 2'd2;

    localparam logic [TYPE_W-1:0] EVT_OFF = 4'd0;
    localparam logic [TYPE_W-1:0] EVT_ON  = 4'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd1;

    localparam logic [PIXEL_W-1:0] CONTRAST_RESET   = 8'd16;
    localparam logic [PIXEL_W-1:0] BRIGHTNESS_RESET = 8'd128;
    localparam logic [PIXEL_W-1:0] PIXEL_RESET      = 8'd128;

    typedef logic [1:0] op_t;

    localparam op_t OP_EVENT_OFF = 2'd0;
    localparam op_t OP_EVENT_ON  = 2'd1;
    localparam op_t OP_READ      = 2'd2;
    localparam op_t OP_HIST      = 2'd3;

    typedef struct packed {
        logic                valid;
        op_t                 op;
        logic [PROD_W-1:0]   prod;
    } dec_t;

endpackage

// ===== rtl/efa_if.sv =====
// Channel interfaces: input items, results and configuration writes.
`timescale 1ns / 1ps
interface efa_item_if;
    import efa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MODE_W-1:0]     mode;
    logic [WORD_W-1:0]     event_word;
    logic [INDEX_W-1:0]    pixel_index;
    logic signed [SAMPLE_W-1:0] diff_sample;

    modport source (output valid, mode, event_word, pixel_index, diff_sample, input ready);
    modport sink (input valid, mode, event_word, pixel_index, diff_sample, output ready);
endinterface

interface efa_result_if;
    import efa_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] gray_level;

    modport source (output valid, gray_level, input ready);
    modport sink (input valid, gray_level, output ready);
endinterface

interface efa_cfg_if;
    import efa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/efa_decode.sv =====
// Input item decode: operation, pixel address and histogram product.
`timescale 1ns / 1ps
module efa_decode #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 320,
    parameter int AW           = 17
) (
    input  logic [efa_pkg::MODE_W-1:0]          mode,
    input  logic [efa_pkg::WORD_W-1:0]          event_word,
    input  logic [efa_pkg::INDEX_W-1:0]         pixel_index,
    input  logic signed [efa_pkg::SAMPLE_W-1:0] diff_sample,
    input  logic [efa_pkg::PIXEL_W-1:0]         contrast,
    output efa_pkg::dec_t                       dec,
    output logic [AW-1:0]                       addr
);
    import efa_pkg::*;

    localparam int PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int LIN_W = 2 * COORD_W + 1;

    logic [TYPE_W-1:0]  evt_type;
    logic [COORD_W-1:0] evt_x;
    logic [COORD_W-1:0] evt_y;
    logic               in_frame;
    logic [LIN_W-1:0]   evt_lin;
    logic               idx_ok;

    assign evt_type = event_word[31:28];
    assign evt_x    = event_word[21:11];
    assign evt_y    = event_word[10:0];
    assign in_frame = ((COORD_W + 1)'(evt_x) < (COORD_W + 1)'(FRAME_WIDTH))
                   && ((COORD_W + 1)'(evt_y) < (COORD_W + 1)'(FRAME_HEIGHT));
    assign evt_lin  = LIN_W'(evt_y) * LIN_W'(FRAME_WIDTH) + LIN_W'(evt_x);
    assign idx_ok   = LIN_W'(pixel_index) < LIN_W'(PIXEL_COUNT);

    always_comb
    begin
        dec.valid = 1'b0;
        dec.op    = OP_HIST;
        dec.prod  = PROD_W'(PROD_W'(diff_sample) * $signed({9'b0, contrast}));
        addr      = AW'(pixel_index);
        case (mode)
            MODE_EVENT:
            begin
                addr = evt_lin[AW-1:0];
                case (evt_type)
                    EVT_OFF:
                    begin
                        dec.valid = in_frame;
                        dec.op    = OP_EVENT_OFF;
                    end
                    EVT_ON:
                    begin
                        dec.valid = in_frame;
                        dec.op    = OP_EVENT_ON;
                    end
                    default:
                    begin
                        dec.valid = 1'b0;
                    end
                endcase
            end
            MODE_READ:
            begin
                dec.valid = idx_ok;
                dec.op    = OP_READ;
            end
            MODE_HIST:
            begin
                dec.valid = 1'b1;
                dec.op    = OP_HIST;
            end
            default:
            begin
                dec.valid = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/efa_frame_mem.sv =====
// Frame memory with registered read and the post-reset clearing sweep.
`timescale 1ns / 1ps
module efa_frame_mem #(
    parameter int DEPTH = 102400,
    parameter int AW    = 17
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [efa_pkg::PIXEL_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [efa_pkg::PIXEL_W-1:0]  rd_data,
    output logic                         busy
);
    import efa_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [AW-1:0]      clr_cnt_next;
    logic               busy_reg;
    logic               busy_next;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [PIXEL_W-1:0] mem_wdata;

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Sweep owns the write port until every pixel holds the reset level.
    assign mem_we    = busy_reg || wr_en;
    assign mem_waddr = busy_reg ? clr_cnt_reg : wr_addr;
    assign mem_wdata = busy_reg ? PIXEL_RESET : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ===== rtl/event_frame_accumulator.sv =====
// Top level: event-to-frame accumulator with read-and-clear and histogram mapping.
`timescale 1ns / 1ps
// Takes one item per clock whenever the result register is free or being
// drained; each result passes the stage A and B registers into the result
// register. The frame lives in one memory with a registered read; every item
// goes through decode, memory read and a modify/write-back stage, and a write
// in the last stage is forwarded to a read of the same pixel issued in the
// same cycle. After reset the block sweeps all FRAME_WIDTH * FRAME_HEIGHT
// pixels to gray level 128, one pixel per clock, and takes no item until the
// sweep ends; configuration writes are taken at all times.
module event_frame_accumulator #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 320
) (
    input  logic        clk,
    input  logic        rst_n,
    efa_cfg_if.sink     cfg,
    efa_item_if.sink    item,
    efa_result_if.source result
);
    import efa_pkg::*;

    localparam int PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    logic [PIXEL_W-1:0] contrast_reg;
    logic [PIXEL_W-1:0] brightness_reg;

    dec_t               dec;
    logic [AW-1:0]      dec_addr;

    logic               a_valid_reg;
    op_t                a_op_reg;
    logic [AW-1:0]      a_addr_reg;
    logic [PROD_W-1:0]  a_prod_reg;

    logic               b_valid_reg;
    op_t                b_op_reg;
    logic [AW-1:0]      b_addr_reg;
    logic [PROD_W-1:0]  b_prod_reg;
    logic               fwd_hit_reg;
    logic [PIXEL_W-1:0] fwd_data_reg;

    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_data_reg;

    logic               adv;
    logic               accept;
    logic               busy;
    logic [PIXEL_W-1:0] rd_data;
    logic [PIXEL_W-1:0] cur;
    logic [PIXEL_W:0]   up_sum;
    logic signed [PROD_W:0] hist_sum;
    logic [PIXEL_W-1:0] hist_val;
    logic               b_wr;
    logic [PIXEL_W-1:0] b_wdata;
    logic               b_res;
    logic [PIXEL_W-1:0] b_rdata;

    // Configuration: always ready, unknown indexes drop.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contrast_reg   <= CONTRAST_RESET;
            brightness_reg <= BRIGHTNESS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_CONTRAST)
            begin
                contrast_reg <= cfg.data;
            end
            else if (cfg.index == CFG_BRIGHTNESS)
            begin
                brightness_reg <= cfg.data;
            end
        end
    end

    // Whole pipeline advances together; hold it while a result waits.
    assign adv        = !out_valid_reg || result.ready;
    assign item.ready = adv && !busy;
    assign accept     = item.valid && item.ready;

    efa_decode #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .AW           (AW)
    ) u_decode (
        .mode        (item.mode),
        .event_word  (item.event_word),
        .pixel_index (item.pixel_index),
        .diff_sample (item.diff_sample),
        .contrast    (contrast_reg),
        .dec         (dec),
        .addr        (dec_addr)
    );

    efa_frame_mem #(
        .DEPTH (PIXEL_COUNT),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (b_wr && adv),
        .wr_addr (b_addr_reg),
        .wr_data (b_wdata),
        .rd_en   (adv),
        .rd_addr (a_addr_reg),
        .rd_data (rd_data),
        .busy    (busy)
    );

    // Modify stage.
    assign cur      = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign up_sum   = {1'b0, cur} + {1'b0, contrast_reg};
    assign hist_sum = (PROD_W + 1)'($signed(b_prod_reg))
                    + $signed({{(PROD_W + 1 - PIXEL_W){1'b0}}, brightness_reg});

    always_comb
    begin
        if (hist_sum < 0)
        begin
            hist_val = '0;
        end
        else if (hist_sum > (PROD_W + 1)'(255))
        begin
            hist_val = '1;
        end
        else
        begin
            hist_val = hist_sum[PIXEL_W-1:0];
        end
    end

    always_comb
    begin
        b_wr    = 1'b0;
        b_wdata = cur;
        b_res   = 1'b0;
        b_rdata = cur;
        case (b_op_reg)
            OP_EVENT_OFF:
            begin
                b_wr    = b_valid_reg;
                b_wdata = (cur >= contrast_reg) ? cur - contrast_reg : '0;
            end
            OP_EVENT_ON:
            begin
                b_wr    = b_valid_reg;
                b_wdata = up_sum[PIXEL_W] ? '1 : up_sum[PIXEL_W-1:0];
            end
            OP_READ:
            begin
                b_wr    = b_valid_reg;
                b_wdata = brightness_reg;
                b_res   = b_valid_reg;
            end
            OP_HIST:
            begin
                b_res   = b_valid_reg;
                b_rdata = hist_val;
            end
            default:
            begin
                b_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= accept && dec.valid;
            b_valid_reg   <= a_valid_reg;
            // Write and read of one pixel at the same edge: take the new value.
            fwd_hit_reg   <= b_wr && a_valid_reg && (a_addr_reg == b_addr_reg);
            out_valid_reg <= b_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_op_reg     <= dec.op;
            a_addr_reg   <= dec_addr;
            a_prod_reg   <= dec.prod;
            b_op_reg     <= a_op_reg;
            b_addr_reg   <= a_addr_reg;
            b_prod_reg   <= a_prod_reg;
            fwd_data_reg <= b_wdata;
            if (b_res)
            begin
                out_data_reg <= b_rdata;
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.gray_level = out_data_reg;

`ifndef NO_ASSERTIONS
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (!item.ready && !a_valid_reg && !b_valid_reg && !out_valid_reg))
        else $error("item in flight during frame clear");

    a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> b_valid_reg)
        else $error("forward flag set with empty modify stage");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(b_valid_reg))
        else $error("result without an item in the modify stage");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(b_addr_reg) && $stable(rd_data) && $stable(fwd_hit_reg)))
        else $error("modify stage changed while stalled");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench of the event frame accumulator.
`timescale 1ns / 1ps
module tb;
    import efa_pkg::*;

    localparam int FRAME_W = 320;
    localparam int FRAME_H = 320;
    localparam int PIXELS  = FRAME_W * FRAME_H;
    localparam int WIN     = 8;
    localparam int TAIL_CYCLES = 8;
    localparam int SQUEEZE_CYCLES = 400;

    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [TYPE_W-1:0]    EVT_FOREIGN_LO = 4'd2;
    localparam logic [TYPE_W-1:0]    EVT_FOREIGN_HI = 4'd15;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]          mode;
        logic [WORD_W-1:0]          word;
        logic [INDEX_W-1:0]         index;
        logic signed [SAMPLE_W-1:0] sample;
    } frame_op_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_TRICKLE} rx_style_t;

    logic clk;
    logic rst_n;

    efa_cfg_if    cfg_ch();
    efa_item_if   item_ch();
    efa_result_if result_ch();

    event_frame_accumulator #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    // frame and register image
    logic [PIXEL_W-1:0] frame_model [PIXELS];
    logic [PIXEL_W-1:0] contrast_q;
    logic [PIXEL_W-1:0] brightness_q;
    logic [PIXEL_W-1:0] gray_expected [$];

    frame_op_t pending_ops [$];
    frame_op_t cur_op;
    int  items_queued;
    int  items_taken;
    bit  took_item;
    int  burst_left;
    int  gap_left;

    rx_style_t  rx_style;
    int         rx_tick;
    logic [7:0] rx_comb;
    logic       rx_ready;
    int         hold_left;
    bit         squeeze_req;
    bit         squeeze_done;

    int fail_count;
    int n_events;
    int n_dropped;
    int n_reads;
    int n_hist;
    int n_unused;
    int n_results;
    int n_writes;
    int stall_cycles;

    int win_x;
    int win_y;

    function automatic logic [PIXEL_W-1:0] sat8(input int v);
        if (v < 0)
        begin
            return '0;
        end
        if (v > 255)
        begin
            return 8'd255;
        end
        return v[PIXEL_W-1:0];
    endfunction

    task automatic predict_item(input frame_op_t op);
        logic [TYPE_W-1:0] kind;
        int x;
        int y;
        int addr;
        int level;
        int gain;
        int offset;
        int s;
        kind   = op.word[31:28];
        x      = op.word[21:11];
        y      = op.word[10:0];
        gain   = contrast_q;
        offset = brightness_q;
        case (op.mode)
            MODE_EVENT:
            begin
                n_events++;
                if ((kind == EVT_OFF || kind == EVT_ON) && x < FRAME_W && y < FRAME_H)
                begin
                    addr  = y * FRAME_W + x;
                    level = frame_model[addr];
                    level = (kind == EVT_ON) ? level + gain : level - gain;
                    frame_model[addr] = sat8(level);
                end
                else
                begin
                    n_dropped++;
                end
            end
            MODE_READ:
            begin
                n_reads++;
                if (op.index < PIXELS)
                begin
                    gray_expected.push_back(frame_model[op.index]);
                    frame_model[op.index] = brightness_q;
                end
            end
            MODE_HIST:
            begin
                n_hist++;
                s = op.sample;
                gray_expected.push_back(sat8(s * gain + offset));
            end
            default:
            begin
                n_unused++;
            end
        endcase
    endtask

    function automatic frame_op_t random_op();
        frame_op_t op;
        op.mode   = MODE_W'($urandom_range(0, 3));
        op.word   = $urandom();
        op.index  = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
        op.sample = SAMPLE_W'($urandom_range(0, 255));
        return op;
    endfunction

    function automatic frame_op_t make_event(input logic [TYPE_W-1:0] kind, input int x,
                                             input int y);
        frame_op_t op;
        op = random_op();
        op.mode = MODE_EVENT;
        op.word[31:28] = kind;
        op.word[21:11] = x[COORD_W-1:0];
        op.word[10:0]  = y[COORD_W-1:0];
        return op;
    endfunction

    function automatic frame_op_t make_read(input int idx);
        frame_op_t op;
        op = random_op();
        op.mode  = MODE_READ;
        op.index = idx[INDEX_W-1:0];
        return op;
    endfunction

    function automatic frame_op_t make_hist(input int s);
        frame_op_t op;
        op = random_op();
        op.mode   = MODE_HIST;
        op.sample = s[SAMPLE_W-1:0];
        return op;
    endfunction

    function automatic logic [TYPE_W-1:0] any_polarity();
        return ($urandom_range(0, 1) != 0) ? EVT_ON : EVT_OFF;
    endfunction

    task automatic push_op(input frame_op_t op);
        pending_ops.push_back(op);
        items_queued++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Events leave no result, so the wait runs on for a tail after the last
    // result before the block counts as idle.
    task automatic wait_idle();
        while (items_taken != items_queued || gray_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Mostly events piled onto a small window and readouts of the same window,
    // so pixels saturate and get read back, plus histogram samples; the rest is noise.
    task automatic run_phase(input int target);
        int counted;
        int pick;
        counted = 0;
        case ($urandom_range(0, 2))
            0: win_x = 0;
            1: win_x = FRAME_W - WIN;
            default: win_x = $urandom_range(0, FRAME_W - WIN);
        endcase
        case ($urandom_range(0, 2))
            0: win_y = 0;
            1: win_y = FRAME_H - WIN;
            default: win_y = $urandom_range(0, FRAME_H - WIN);
        endcase
        while (counted < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                push_op(make_event(any_polarity(), win_x + $urandom_range(0, WIN - 1),
                                   win_y + $urandom_range(0, WIN - 1)));
                counted++;
            end
            else if (pick < 65)
            begin
                push_op(make_read((win_y + $urandom_range(0, WIN - 1)) * FRAME_W
                                  + win_x + $urandom_range(0, WIN - 1)));
                counted++;
            end
            else if (pick < 77)
            begin
                push_op(make_hist($urandom_range(0, 255)));
                counted++;
            end
            else if (pick < 83)
            begin
                push_op(make_read($urandom_range(0, (1 << INDEX_W) - 1)));
            end
            else if (pick < 90)
            begin
                push_op(make_event(TYPE_W'($urandom_range(0, 15)), $urandom_range(0, 2047),
                                   $urandom_range(0, 2047)));
            end
            else if (pick < 95)
            begin
                push_op(make_event(any_polarity(), $urandom_range(0, FRAME_W - 1),
                                   $urandom_range(0, FRAME_H - 1)));
                counted++;
            end
            else
            begin
                cur_op = random_op();
                cur_op.mode = MODE_UNUSED;
                push_op(cur_op);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // sender: bursts of random length with random gaps
    always @(negedge clk)
    begin
        if (!item_ch.valid || took_item)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                item_ch.valid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                cur_op = pending_ops.pop_front();
                item_ch.valid       <= 1'b1;
                item_ch.mode        <= cur_op.mode;
                item_ch.event_word  <= cur_op.word;
                item_ch.pixel_index <= cur_op.index;
                item_ch.diff_sample <= cur_op.sample;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switched now and then, plus one long hold-off
    always @(negedge clk)
    begin
        if (squeeze_req && !squeeze_done)
        begin
            hold_left    = SQUEEZE_CYCLES;
            squeeze_done = 1'b1;
        end
        if (rx_tick == 0)
        begin
            rx_style = rx_style_t'($urandom_range(0, 3));
            rx_tick  = $urandom_range(20, 120);
        end
        else
        begin
            rx_tick--;
        end
        rx_comb = {rx_comb[0], rx_comb[7:1]};
        if (hold_left > 0)
        begin
            hold_left--;
            rx_ready = 1'b0;
        end
        else
        begin
            case (rx_style)
                RX_OPEN:    rx_ready = 1'b1;
                RX_COIN:    rx_ready = 1'($urandom_range(0, 1));
                RX_COMB:    rx_ready = rx_comb[0];
                RX_TRICKLE: rx_ready = ($urandom_range(0, 3) == 0);
                default:    rx_ready = 1'b1;
            endcase
        end
        result_ch.ready <= rx_ready;
    end

    // check results, then predict the item taken at this edge
    always @(posedge clk)
    begin
        took_item = rst_n && item_ch.valid && item_ch.ready;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                n_results++;
                if (gray_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, gray_level %0d with nothing outstanding",
                             $time, result_ch.gray_level);
                    fail_count++;
                end
                else if (gray_expected[0] !== result_ch.gray_level)
                begin
                    $display("%0t: gray_level mismatch, expected %0d, got %0d",
                             $time, gray_expected[0], result_ch.gray_level);
                    fail_count++;
                    void'(gray_expected.pop_front());
                end
                else
                begin
                    void'(gray_expected.pop_front());
                end
            end
            if (item_ch.valid && !item_ch.ready && items_taken > 0)
            begin
                stall_cycles++;
            end
            if (took_item)
            begin
                cur_op.mode   = item_ch.mode;
                cur_op.word   = item_ch.event_word;
                cur_op.index  = item_ch.pixel_index;
                cur_op.sample = item_ch.diff_sample;
                predict_item(cur_op);
                items_taken++;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                n_writes++;
                if (cfg_ch.index == CFG_CONTRAST)
                begin
                    contrast_q = cfg_ch.data;
                end
                else if (cfg_ch.index == CFG_BRIGHTNESS)
                begin
                    brightness_q = cfg_ch.data;
                end
            end
        end
    end

    initial
    begin
        int settings [9][2];
        settings = '{'{255, 0}, '{0, 255}, '{255, 255}, '{0, 0}, '{1, 128},
                     '{-1, -1}, '{-1, -1}, '{-1, -1}, '{-1, -1}};
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        item_ch.valid       = 1'b0;
        item_ch.mode        = '0;
        item_ch.event_word  = '0;
        item_ch.pixel_index = '0;
        item_ch.diff_sample = '0;
        result_ch.ready     = 1'b0;
        rx_style  = RX_OPEN;
        rx_comb   = 8'b1101_1011;
        contrast_q   = CONTRAST_RESET;
        brightness_q = BRIGHTNESS_RESET;
        for (int i = 0; i < PIXELS; i++)
        begin
            frame_model[i] = PIXEL_RESET;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // writes past the register list must leave contrast and brightness alone
        cfg_write(CFG_SPARE_2, CFG_DATA_W'($urandom_range(0, 255)));
        cfg_write(CFG_SPARE_3, CFG_DATA_W'($urandom_range(0, 255)));

        push_op(make_read(0));
        push_op(make_read(PIXELS - 1));
        push_op(make_read(PIXELS));
        push_op(make_read((1 << INDEX_W) - 1));
        push_op(make_hist(-128));
        push_op(make_hist(127));
        push_op(make_hist(0));
        push_op(make_hist(-1));
        push_op(make_event(EVT_ON, 0, 0));
        push_op(make_event(EVT_OFF, FRAME_W - 1, FRAME_H - 1));
        push_op(make_event(EVT_ON, FRAME_W, 0));
        push_op(make_event(EVT_OFF, 0, FRAME_H));
        push_op(make_event(EVT_ON, 2047, 2047));
        push_op(make_event(EVT_FOREIGN_LO, 5, 5));
        push_op(make_event(EVT_FOREIGN_HI, 5, 5));
        cur_op = random_op();
        cur_op.mode = MODE_UNUSED;
        push_op(cur_op);
        push_op(make_read(0));
        push_op(make_read(PIXELS - 1));
        push_op(make_read(5 * FRAME_W + 5));
        push_op(make_read(FRAME_W));
        push_op(make_read(0));
        wait_idle();

        for (int p = 0; p < 9; p++)
        begin
            if (settings[p][0] < 0)
            begin
                settings[p][0] = $urandom_range(0, 255);
                settings[p][1] = $urandom_range(0, 255);
            end
            cfg_write(CFG_CONTRAST, CFG_DATA_W'(settings[p][0]));
            cfg_write(CFG_BRIGHTNESS, CFG_DATA_W'(settings[p][1]));
            if (p == 2)
            begin
                squeeze_req = 1'b1;
            end
            run_phase(76);
            wait_idle();
        end

        $display("Covered %0d events (%0d dropped), %0d reads, %0d samples, %0d unused items",
                 n_events, n_dropped, n_reads, n_hist, n_unused);
        $display("%0d results checked, %0d register writes, input held back for %0d cycles",
                 n_results, n_writes, stall_cycles);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
